[rtl/sbc_pkg.sv]
`timescale 1ns / 1ps

package sbc_pkg;

  // Screen geometry and transparent color key
  localparam int SCREEN_COLS = 240;
  localparam int SCREEN_ROWS = 320;
  localparam logic [15:0] TRANSPARENT_KEY = 16'h0001;

  // Field widths
  localparam int PIX_W   = 16;
  localparam int CNT_W   = 9;
  localparam int ORG_W   = 10;
  localparam int POS_W   = ORG_W + 1;
  localparam int ADDR_W  = 17;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes, byte address 4*index
  typedef enum logic [1:0] {
    REG_X_ORIGIN,
    REG_Y_ORIGIN,
    REG_SPRITE_WIDTH,
    REG_SPRITE_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic signed [ORG_W-1:0] x_origin;
    logic signed [ORG_W-1:0] y_origin;
    logic [CNT_W-1:0]        sprite_width;
    logic [CNT_W-1:0]        sprite_height;
  } sbc_cfg_t;

  // One pixel with its position inside the sprite
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic             done;
  } sbc_item_t;

endpackage

[rtl/sbc_if.sv]
`timescale 1ns / 1ps

interface sbc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface sbc_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [16:0] write_addr;
  logic [15:0] write_data;
  logic        sprite_done;

  modport source (output valid, output write_enable, output write_addr,
                  output write_data, output sprite_done, input ready);
  modport sink (input valid, input write_enable, input write_addr,
                input write_data, input sprite_done, output ready);
endinterface

[rtl/sprite_blit_clip_colorkey_unit.sv]
`timescale 1ns / 1ps

// Each pixel is held first in the pixel stage register and then in the output register, which
// offers its result on out valid.
// Throughput: one pixel per cycle; input ready drops only when both stages hold stalled items.
// Every input pixel yields exactly one result; pixels clipped or keyed out have write_enable low.
// Reset (rst_n low, synchronous) empties both stages, zeroes the sprite counters and sets
// origin 0,0 and sprite size 1x1.
module sprite_blit_clip_colorkey_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  sbc_in_if.sink                       in_ch,
  sbc_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sbc_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [sbc_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [sbc_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import sbc_pkg::*;

  sbc_cfg_t  cfg;
  logic      s1_valid;
  logic      s1_ready;
  sbc_item_t s1_item;

  sbc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sbc_pixel_stage u_pixel (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_ready (s1_ready)
  );

  sbc_clip_stage u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_ready (s1_ready),
    .out_ch   (out_ch)
  );

endmodule

[rtl/sbc_cfg_regs.sv]
`timescale 1ns / 1ps

module sbc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sbc_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [sbc_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [sbc_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready,
  output sbc_pkg::sbc_cfg_t            cfg
);
  import sbc_pkg::*;

  sbc_cfg_t cfg_r;
  sbc_cfg_t cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg        = cfg_r;

  // Decode the register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_X_ORIGIN:      cfg_nxt.x_origin      = cfg_pwdata[ORG_W-1:0];
        REG_Y_ORIGIN:      cfg_nxt.y_origin      = cfg_pwdata[ORG_W-1:0];
        REG_SPRITE_WIDTH:  cfg_nxt.sprite_width  = cfg_pwdata[CNT_W-1:0];
        REG_SPRITE_HEIGHT: cfg_nxt.sprite_height = cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin      <= '0;
      cfg_r.y_origin      <= '0;
      cfg_r.sprite_width  <= CNT_W'(1);
      cfg_r.sprite_height <= CNT_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      REG_X_ORIGIN:      cfg_prdata = PDATA_W'(cfg_r.x_origin);
      REG_Y_ORIGIN:      cfg_prdata = PDATA_W'(cfg_r.y_origin);
      REG_SPRITE_WIDTH:  cfg_prdata = PDATA_W'(cfg_r.sprite_width);
      REG_SPRITE_HEIGHT: cfg_prdata = PDATA_W'(cfg_r.sprite_height);
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

[rtl/sbc_pixel_stage.sv]
`timescale 1ns / 1ps

module sbc_pixel_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  sbc_pkg::sbc_cfg_t   cfg,
  sbc_in_if.sink              in_ch,
  output logic                s1_valid,
  output sbc_pkg::sbc_item_t  s1_item,
  input  logic                s1_ready
);
  import sbc_pkg::*;

  logic [CNT_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [CNT_W-1:0] row_cnt_r, row_cnt_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  sbc_item_t        item_r;
  logic [CNT_W-1:0] last_col_idx;
  logic [CNT_W-1:0] last_row_idx;
  logic             last_col;
  logic             done;
  logic             in_xfer;
  logic             s1_xfer;

  // Stage register refills as soon as its item moves on
  assign s1_xfer     = s1_valid_r && s1_ready;
  assign in_ch.ready = !s1_valid_r || s1_ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Zero size acts as one
  assign last_col_idx = (cfg.sprite_width == '0) ? '0 : cfg.sprite_width - CNT_W'(1);
  assign last_row_idx = (cfg.sprite_height == '0) ? '0 : cfg.sprite_height - CNT_W'(1);
  assign last_col     = col_cnt_r >= last_col_idx;
  assign done         = last_col && (row_cnt_r >= last_row_idx);

  // Advance the raster counters on every input transfer
  always_comb begin
    col_cnt_nxt  = col_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    s1_valid_nxt = s1_valid_r;
    if (s1_xfer) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
      if (done) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
      end else if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_cnt_r + CNT_W'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture the pixel with its sprite position
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.pixel <= in_ch.pixel;
      item_r.col   <= col_cnt_r;
      item_r.row   <= row_cnt_r;
      item_r.done  <= done;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = item_r;

`ifndef SYNTHESIS
  a_wrap_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && done |=> col_cnt_r == '0 && row_cnt_r == '0)
    else $error("counters did not wrap after the final pixel");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_ready |=> s1_valid_r && $stable(item_r))
    else $error("stalled stage item changed");
`endif

endmodule

[rtl/sbc_clip_stage.sv]
`timescale 1ns / 1ps

module sbc_clip_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  sbc_pkg::sbc_cfg_t   cfg,
  input  logic                s1_valid,
  input  sbc_pkg::sbc_item_t  s1_item,
  output logic                s1_ready,
  sbc_out_if.source           out_ch
);
  import sbc_pkg::*;

  logic signed [POS_W-1:0] col_pos;
  logic signed [POS_W-1:0] row_pos;
  logic                    on_screen;
  logic                    we;
  logic [ADDR_W-1:0]       addr_full;
  logic                    out_valid_r, out_valid_nxt;
  logic                    we_r;
  logic [ADDR_W-1:0]       addr_r;
  logic [PIX_W-1:0]        data_r;
  logic                    done_r;
  logic                    load;

  // Screen position from the origin
  assign col_pos = $signed({cfg.x_origin[ORG_W-1], cfg.x_origin})
                 + $signed({2'b00, s1_item.col});
  assign row_pos = $signed({cfg.y_origin[ORG_W-1], cfg.y_origin})
                 + $signed({2'b00, s1_item.row});

  // Clip on the left, right, top and bottom edges and drop the color key
  assign on_screen = !col_pos[POS_W-1] && !row_pos[POS_W-1]
                  && ({1'b0, col_pos[POS_W-2:0]} < POS_W'(SCREEN_COLS))
                  && ({1'b0, row_pos[POS_W-2:0]} < POS_W'(SCREEN_ROWS));
  assign we        = on_screen && (s1_item.pixel != TRANSPARENT_KEY);
  assign addr_full = ADDR_W'(ADDR_W'(row_pos[POS_W-2:0]) * ADDR_W'(SCREEN_COLS))
                   + ADDR_W'(col_pos[POS_W-2:0]);

  // Output register takes a new item when empty or draining
  assign s1_ready = !out_valid_r || out_ch.ready;
  assign load     = s1_valid && s1_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      we_r   <= we;
      addr_r <= we ? addr_full : '0;
      data_r <= we ? s1_item.pixel : '0;
      done_r <= s1_item.done;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.write_enable = we_r;
  assign out_ch.write_addr   = addr_r;
  assign out_ch.write_data   = data_r;
  assign out_ch.sprite_done  = done_r;

`ifndef SYNTHESIS
  a_addr_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && we_r |-> addr_r < ADDR_W'(SCREEN_COLS * SCREEN_ROWS))
    else $error("framebuffer write beyond the screen");

  a_quiet_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !we_r |-> addr_r == '0 && data_r == '0)
    else $error("disabled write carries nonzero payload");

  a_key_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    load && s1_item.pixel == TRANSPARENT_KEY |=> !we_r)
    else $error("transparent pixel written");
`endif

endmodule
